// ===== sv/ecc_pkg.sv =====
// ============================================================================
// ecc_pkg: elevator car controller shared types
// Item and result layouts, operation and state codes, and floor helpers.
// ============================================================================
package ecc_pkg;

    localparam int FLOOR_W    = 5;
    localparam int FLOORS     = 16;
    localparam int TBL_AW     = $clog2(FLOORS);
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 1;

    typedef enum logic [1:0] {
        MODE_HALL  = 2'd0,
        MODE_CMD   = 2'd1,
        MODE_STEP  = 2'd2,
        MODE_TABLE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_MOVE    = 2'd0,
        ST_WAITING = 2'd1,
        ST_SET     = 2'd2,
        ST_REMOVE  = 2'd3
    } lift_state_t;

    typedef struct packed {
        mode_t                mode;
        logic [FLOOR_W-1:0]   floor;
        logic                 group_waiting;
        logic [FLOOR_W-1:0]   group_destination;
    } item_t;

    typedef struct packed {
        logic                 was_step;
        lift_state_t          lift_state;
        logic [FLOOR_W-1:0]   current_floor;
        logic [FLOOR_W-1:0]   goal_floor;
        logic                 car_empty;
        logic                 queue_overflow;
    } result_t;

    typedef struct packed {
        logic                 pop;
        logic                 push;
        logic [FLOOR_W-1:0]   data;
    } fifo_ctl_t;

    typedef struct packed {
        logic                 nonempty;
        logic                 full;
        logic [FLOOR_W-1:0]   head;
    } fifo_sts_t;

    function automatic logic floor_ok(input logic [FLOOR_W-1:0] f);
        return (f != '0) && (f <= FLOOR_W'(FLOORS));
    endfunction

    function automatic logic [TBL_AW-1:0] floor_idx(input logic [FLOOR_W-1:0] f);
        logic [FLOOR_W-1:0] z;
        z = f - 1'b1;
        return z[TBL_AW-1:0];
    endfunction

endpackage

// ===== sv/ecc_ram.sv =====
// ============================================================================
// ecc_ram: generic single-port-write RAM
// One write port and one read port; read data is registered.
// ============================================================================
module ecc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ecc_fifo.sv =====
// ============================================================================
// ecc_fifo: floor queue with head lookahead
// Circular buffer in RAM. The RAM is read at the next head address every
// cycle, so the head entry is ready when the next transaction arrives.
// ============================================================================
module ecc_fifo #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ecc_pkg::fifo_ctl_t ctl,
    output ecc_pkg::fifo_sts_t sts
);
    import ecc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    logic [PTR_W-1:0]   head_reg, head_next, head_inc, tail;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, cnt_pop;
    logic [SUM_W-1:0]   tail_sum;
    logic               byp_reg, byp_next;
    logic [FLOOR_W-1:0] byp_data_reg;
    logic [FLOOR_W-1:0] rd_data;
    logic               full, do_push;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign do_push  = ctl.push && (!full || ctl.pop);
    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_next = ctl.pop ? head_inc : head_reg;
    assign cnt_pop  = cnt_reg - CNT_W'(ctl.pop);
    assign cnt_next = cnt_pop + CNT_W'(do_push);
    // the push lands behind whatever is left after this transaction's pop
    assign tail_sum = SUM_W'(head_next) + SUM_W'(cnt_pop);
    assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(tail_sum);
    assign byp_next = do_push && (tail == head_next);

    ecc_ram #(
        .WIDTH (FLOOR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (tail),
        .wr_data (ctl.data),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cnt_reg  <= '0;
            byp_reg  <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            byp_reg  <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ctl.data;
    end

    assign sts.nonempty = (cnt_reg != '0);
    assign sts.full     = full;
    assign sts.head     = byp_reg ? byp_data_reg : rd_data;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("fifo count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> cnt_reg != '0)
        else $error("pop from empty fifo");

    a_drop_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.push && full && !ctl.pop) |=> cnt_reg == CNT_W'(DEPTH))
        else $error("dropped push changed fifo count");
`endif

endmodule

// ===== sv/ecc_core.sv =====
// ============================================================================
// ecc_core: car state and step logic
// Holds car floor, goal, empty flag and the floor waiting table, and works
// out one result per transaction plus the queue push and pop requests.
// ============================================================================
module ecc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  ecc_pkg::item_t     item,
    input  ecc_pkg::fifo_sts_t hall_sts,
    input  ecc_pkg::fifo_sts_t cmd_sts,
    output ecc_pkg::fifo_ctl_t hall_ctl,
    output ecc_pkg::fifo_ctl_t cmd_ctl,
    output ecc_pkg::result_t   result
);
    import ecc_pkg::*;

    logic [FLOOR_W-1:0] car_reg, car_next;
    logic [FLOOR_W-1:0] tgt_reg, tgt_next;
    logic               empty_reg, empty_next;
    logic [FLOORS-1:0]  wait_reg;
    logic [FLOOR_W-1:0] dest_reg [FLOORS];

    logic               tbl_we;
    logic               tbl_wait_d;
    logic [FLOOR_W-1:0] tbl_dest_d;
    lift_state_t        st;
    logic               was, ovf;

    always_comb
    begin
        logic [FLOOR_W-1:0] tgt;
        logic [FLOOR_W-1:0] nf;
        logic [FLOOR_W-1:0] d;
        logic               up;
        logic               w;

        car_next   = car_reg;
        tgt_next   = tgt_reg;
        empty_next = empty_reg;
        st         = ST_MOVE;
        was        = 1'b0;
        ovf        = 1'b0;
        hall_ctl   = '0;
        cmd_ctl    = '0;
        tbl_we     = 1'b0;
        tbl_wait_d = 1'b0;
        tbl_dest_d = '0;
        tgt        = tgt_reg;
        nf         = car_reg;
        d          = '0;
        up         = 1'b0;
        w          = 1'b0;

        if (fire)
        begin
            unique case (item.mode)
                MODE_HALL:
                begin
                    if (floor_ok(item.floor))
                    begin
                        hall_ctl.push = 1'b1;
                        hall_ctl.data = item.floor;
                        ovf           = hall_sts.full;
                    end
                end
                MODE_CMD:
                begin
                    if (floor_ok(item.floor))
                    begin
                        cmd_ctl.push = 1'b1;
                        cmd_ctl.data = item.floor;
                        ovf          = cmd_sts.full;
                    end
                end
                MODE_TABLE:
                begin
                    if (floor_ok(item.floor))
                    begin
                        tbl_we     = 1'b1;
                        tbl_wait_d = item.group_waiting && floor_ok(item.group_destination);
                        tbl_dest_d = tbl_wait_d ? item.group_destination : '0;
                    end
                end
                MODE_STEP:
                begin
                    was = 1'b1;
                    if (empty_reg)
                    begin
                        if (tgt_reg == '0 && !hall_sts.nonempty)
                        begin
                            st = ST_WAITING;
                        end
                        else
                        begin
                            if (tgt_reg == '0)
                            begin
                                tgt          = hall_sts.head;
                                hall_ctl.pop = 1'b1;
                            end
                            tgt_next = tgt;
                            if (car_reg < tgt)
                            begin
                                car_next = car_reg + 1'b1;
                            end
                            else if (car_reg > tgt)
                            begin
                                car_next = car_reg - 1'b1;
                            end
                            else
                            begin
                                // arrived at the call: board and serve commands
                                tgt_next   = '0;
                                empty_next = 1'b0;
                                st         = ST_SET;
                            end
                        end
                    end
                    else
                    begin
                        if (tgt_reg == '0 && !cmd_sts.nonempty)
                        begin
                            empty_next = 1'b1;
                            st         = ST_WAITING;
                        end
                        else
                        begin
                            if (tgt_reg == '0)
                            begin
                                tgt         = cmd_sts.head;
                                cmd_ctl.pop = 1'b1;
                            end
                            if (car_reg == tgt)
                            begin
                                tgt_next = '0;
                                st       = ST_REMOVE;
                            end
                            else
                            begin
                                up       = (car_reg < tgt);
                                nf       = up ? car_reg + 1'b1 : car_reg - 1'b1;
                                car_next = nf;
                                tgt_next = tgt;
                                w        = wait_reg[floor_idx(nf)];
                                d        = dest_reg[floor_idx(nf)];
                                // pick up a group heading the same way
                                if (w && (up ? (d > nf) : (d < nf)))
                                begin
                                    st = ST_SET;
                                    if (up ? (d < tgt) : (d > tgt))
                                    begin
                                        cmd_ctl.push = 1'b1;
                                        cmd_ctl.data = tgt;
                                        ovf          = cmd_sts.full && !cmd_ctl.pop;
                                        tgt_next     = d;
                                    end
                                    else if (d != tgt)
                                    begin
                                        cmd_ctl.push = 1'b1;
                                        cmd_ctl.data = d;
                                        ovf          = cmd_sts.full && !cmd_ctl.pop;
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    st = ST_MOVE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            car_reg   <= FLOOR_W'(1);
            tgt_reg   <= '0;
            empty_reg <= 1'b1;
            wait_reg  <= '0;
            for (int i = 0; i < FLOORS; i++)
            begin
                dest_reg[i] <= '0;
            end
        end
        else
        begin
            car_reg   <= car_next;
            tgt_reg   <= tgt_next;
            empty_reg <= empty_next;
            if (tbl_we)
            begin
                wait_reg[floor_idx(item.floor)] <= tbl_wait_d;
                dest_reg[floor_idx(item.floor)] <= tbl_dest_d;
            end
        end
    end

    assign result.was_step       = was;
    assign result.lift_state     = st;
    assign result.current_floor  = car_next;
    assign result.goal_floor     = tgt_next;
    assign result.car_empty      = empty_next;
    assign result.queue_overflow = ovf;

`ifndef ASSERT_OFF
    a_car_range: assert property (@(posedge clk) disable iff (!rst_n)
        car_reg != '0 && car_reg <= FLOOR_W'(FLOORS))
        else $error("car floor out of range");

    a_one_floor: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (car_reg == $past(car_reg) || car_reg == $past(car_reg) + 1'b1
                  || car_reg == $past(car_reg) - 1'b1))
        else $error("car moved more than one floor");

    a_hall_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        hall_ctl.pop |-> (empty_reg && tgt_reg == '0))
        else $error("hall call taken while car occupied or busy");
`endif

endmodule

// ===== sv/elevator_car_controller_core.sv =====
// ============================================================================
// elevator_car_controller_core: single lift car controller
// Input register, step logic with hall and command queues, result register.
// ============================================================================
// Takes one transaction per clock while the output side is not stalled and
// returns one result per transaction. The whole step (queue head, one-floor
// move, waiting-table lookup, requeue) is done combinationally between the
// input register and the result register; each queue RAM is read in the
// cycle before at its next head address, which keeps the rate at one
// transaction per cycle while the output is not stalled. The input register
// can take a transaction while a result waits on the output. Queue RAMs are
// not cleared: entries are only used after they are written.
module elevator_car_controller_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [4:0] floor, [5] group_waiting, [10:6] group_destination, [15:11] zero
    input  logic [ecc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // [1:0] mode
    input  logic [ecc_pkg::IN_USER_W-1:0]        s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [1:0] lift_state, [6:2] current_floor, [11:7] goal_floor,
    // [12] car_empty, [13] queue_overflow, [15:14] zero
    output logic [ecc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // [0] was_step
    output logic [ecc_pkg::OUT_USER_W-1:0]       m_axis_tuser
);
    import ecc_pkg::*;

    logic      in_valid_reg, in_valid_next;
    item_t     item_reg;
    logic      out_valid_reg, out_valid_next;
    result_t   result_reg;
    result_t   result;
    logic      fire, in_take;
    fifo_ctl_t hall_ctl, cmd_ctl;
    fifo_sts_t hall_sts, cmd_sts;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.mode              <= mode_t'(s_axis_tuser);
            item_reg.floor             <= s_axis_tdata[4:0];
            item_reg.group_waiting     <= s_axis_tdata[5];
            item_reg.group_destination <= s_axis_tdata[10:6];
        end
        if (fire)
        begin
            result_reg <= result;
        end
    end

    ecc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_hall_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (hall_ctl),
        .sts   (hall_sts)
    );

    ecc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cmd_ctl),
        .sts   (cmd_sts)
    );

    ecc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item_reg),
        .hall_sts (hall_sts),
        .cmd_sts  (cmd_sts),
        .hall_ctl (hall_ctl),
        .cmd_ctl  (cmd_ctl),
        .result   (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = result_reg.was_step;
    assign m_axis_tdata  = {2'b00,
                            result_reg.queue_overflow,
                            result_reg.car_empty,
                            result_reg.goal_floor,
                            result_reg.current_floor,
                            result_reg.lift_state};

endmodule
